@@ rtl/epid_pkg.sv @@
// ----------------------------------------------------------------------------
// Encoder PID controller package
// Shared widths, register indexes and the records passed between the stages.
// ----------------------------------------------------------------------------
package epid_pkg;

  localparam int unsigned PosW  = 32;
  localparam int unsigned ErrW  = 32;
  localparam int unsigned SumW  = 48;
  localparam int unsigned GainW = 32;
  localparam int unsigned UW    = 82;
  localparam int unsigned DutyW = 8;
  localparam int unsigned IdxW  = 2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [IdxW-1:0] REG_KP = 2'd0;
  localparam logic [IdxW-1:0] REG_KD = 2'd1;
  localparam logic [IdxW-1:0] REG_KI = 2'd2;

  localparam logic [DutyW-1:0] DUTY_MAX = 8'd255;

  typedef struct packed {
    logic signed [GainW-1:0] kp;
    logic signed [GainW-1:0] kd;
    logic signed [GainW-1:0] ki;
  } gains_t;

  typedef struct packed {
    logic signed [ErrW-1:0] err;
    logic signed [ErrW:0]   derr;
    logic signed [SumW-1:0] sum;
    logic [PosW-1:0]        pos;
  } tick_t;

  typedef struct packed {
    logic signed [UW-1:0] u;
    logic [PosW-1:0]      pos;
  } law_t;

endpackage

@@ rtl/epid_track.sv @@
// ----------------------------------------------------------------------------
// Encoder tracking and error state
// Registers the input beat, counts encoder steps and forms error terms.
// ----------------------------------------------------------------------------
module epid_track import epid_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  opcode_i,
  input  logic                  enc_a_i,
  input  logic                  enc_b_i,
  input  logic signed [ErrW-1:0] target_i,
  output logic                  tick_valid_o,
  input  logic                  tick_ready_i,
  output tick_t                 tick_o
);

  logic                   in_vld_q;
  logic                   op_q;
  logic                   a_q;
  logic                   b_q;
  logic signed [ErrW-1:0] target_q;

  logic                   last_a_q;
  logic [PosW-1:0]        pos_q;
  logic signed [ErrW-1:0] last_err_q;
  logic signed [SumW-1:0] sum_q;

  logic                   tick_vld_q;
  tick_t                  tick_q;

  logic                   tick_en;
  logic                   fire;
  logic signed [ErrW:0]   diff_wide;
  logic signed [ErrW-1:0] err_d;
  logic signed [SumW:0]   sum_wide;
  logic signed [SumW-1:0] sum_d;
  logic signed [ErrW:0]   derr_d;
  logic [PosW-1:0]        pos_d;

  assign tick_en    = !tick_vld_q || tick_ready_i;
  assign fire       = in_vld_q && ((op_q == OP_SAMPLE) || tick_en);
  assign in_ready_o = !in_vld_q || fire;

  always_comb begin
    diff_wide = {target_q[ErrW-1], target_q} - {pos_q[PosW-1], pos_q};
    if (diff_wide[ErrW] != diff_wide[ErrW-1]) begin
      err_d = diff_wide[ErrW] ? {1'b1, {(ErrW-1){1'b0}}} : {1'b0, {(ErrW-1){1'b1}}};
    end else begin
      err_d = diff_wide[ErrW-1:0];
    end
    sum_wide = {sum_q[SumW-1], sum_q} + {{(SumW-ErrW+1){err_d[ErrW-1]}}, err_d};
    if (sum_wide[SumW] != sum_wide[SumW-1]) begin
      sum_d = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end else begin
      sum_d = sum_wide[SumW-1:0];
    end
    derr_d = {err_d[ErrW-1], err_d} - {last_err_q[ErrW-1], last_err_q};
    pos_d  = pos_q;
    if (a_q && !last_a_q) begin
      pos_d = b_q ? pos_q + 32'd1 : pos_q - 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q   <= 1'b0;
      tick_vld_q <= 1'b0;
      last_a_q   <= 1'b0;
      pos_q      <= '0;
      last_err_q <= '0;
      sum_q      <= '0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (tick_en) begin
        tick_vld_q <= fire && (op_q == OP_TICK);
      end
      if (fire && (op_q == OP_SAMPLE)) begin
        last_a_q <= a_q;
        pos_q    <= pos_d;
      end
      if (fire && (op_q == OP_TICK)) begin
        last_err_q <= err_d;
        sum_q      <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      op_q     <= opcode_i;
      a_q      <= enc_a_i;
      b_q      <= enc_b_i;
      target_q <= target_i;
    end
    if (fire && (op_q == OP_TICK)) begin
      tick_q.err  <= err_d;
      tick_q.derr <= derr_d;
      tick_q.sum  <= sum_d;
      tick_q.pos  <= pos_q;
    end
  end

  assign tick_valid_o = tick_vld_q;
  assign tick_o       = tick_q;

endmodule

@@ rtl/epid_law.sv @@
// ----------------------------------------------------------------------------
// PID control law
// Pipelined gain products and their sum into one signed Q66.16 control value.
// ----------------------------------------------------------------------------
module epid_law import epid_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  gains_t gains_i,
  input  logic   tick_valid_i,
  output logic   tick_ready_o,
  input  tick_t  tick_i,
  output logic   law_valid_o,
  input  logic   law_ready_i,
  output law_t   law_o
);

  logic v2_q, v3_q, v4_q;
  logic en2, en3, en4;

  logic signed [63:0] pe_q;
  logic signed [64:0] pd_q;
  logic signed [56:0] pl_q;
  logic signed [55:0] ph_q;
  logic [PosW-1:0]    pos2_q;

  logic signed [65:0] a3_q;
  logic signed [80:0] b3_q;
  logic [PosW-1:0]    pos3_q;

  law_t               law_q;

  logic signed [63:0] pe_d;
  logic signed [64:0] pd_d;
  logic signed [56:0] pl_d;
  logic signed [55:0] ph_d;

  assign en4          = !v4_q || law_ready_i;
  assign en3          = !v3_q || en4;
  assign en2          = !v2_q || en3;
  assign tick_ready_o = en2;

  assign pe_d = $signed(gains_i.kp) * $signed(tick_i.err);
  assign pd_d = $signed(gains_i.kd) * $signed(tick_i.derr);
  assign pl_d = $signed(gains_i.ki) * $signed({1'b0, tick_i.sum[23:0]});
  assign ph_d = $signed(gains_i.ki) * $signed(tick_i.sum[47:24]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en2) begin
        v2_q <= tick_valid_i;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      pe_q   <= pe_d;
      pd_q   <= pd_d;
      pl_q   <= pl_d;
      ph_q   <= ph_d;
      pos2_q <= tick_i.pos;
    end
    if (en3) begin
      a3_q   <= {{2{pe_q[63]}}, pe_q} + {pd_q[64], pd_q};
      b3_q   <= {ph_q[55], ph_q, 24'd0} + {{24{pl_q[56]}}, pl_q};
      pos3_q <= pos2_q;
    end
    if (en4) begin
      law_q.u   <= {{16{a3_q[65]}}, a3_q} + {b3_q[80], b3_q};
      law_q.pos <= pos3_q;
    end
  end

  assign law_valid_o = v4_q;
  assign law_o       = law_q;

endmodule

@@ rtl/epid_drive.sv @@
// ----------------------------------------------------------------------------
// Bridge drive output stage
// Turns the control value into duty and direction and holds the result beat.
// ----------------------------------------------------------------------------
module epid_drive import epid_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        law_valid_i,
  output logic        law_ready_o,
  input  law_t        law_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [47:0] out_data_o
);

  logic                  vld_q;
  logic [47:0]           data_q;
  logic                  neg;
  logic [UW-1:0]         mag;
  logic [DutyW-1:0]      duty;

  assign law_ready_o = !vld_q || out_ready_i;

  always_comb begin
    neg  = law_i.u[UW-1];
    mag  = neg ? (~law_i.u + 82'd1) : law_i.u;
    duty = (|mag[UW-1:24]) ? DUTY_MAX : mag[23:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (law_ready_o) begin
      vld_q <= law_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (law_ready_o) begin
      data_q <= {6'd0, law_i.pos, neg, !neg, duty};
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule

@@ rtl/encoder_pid_position_controller.sv @@
// ----------------------------------------------------------------------------
// Encoder PID position controller
// Counts encoder steps and runs a PID update with H-bridge output per tick.
// ----------------------------------------------------------------------------
// The block takes one input beat every clock, encoder samples and control
// ticks alike, while the output is not stalled. A sample moves the position
// on a rising edge of channel A and gives no result. A tick gives one result
// beat; the three gain products and their sum run in a six-stage pipeline
// (input, error, product, add, sum and output registers) whose error state
// is updated in its second stage, so ticks and samples may follow each other
// in consecutive cycles. While results wait on the output the input stays
// open until six ticks are held in the pipeline; the sixth then waits in the
// input register and holds back every beat behind it, samples included,
// until the output moves. The gain registers are always ready and take
// effect on the next cycle; write them while no tick is in flight.
module encoder_pid_position_controller import epid_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [39:0]     s_axis_tdata,  // enc_a, enc_b, target[31:0], zero pad
  input  logic [0:0]      s_axis_tuser,  // opcode
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [47:0]     m_axis_tdata,  // duty[7:0], drive_in1, drive_in2,
                                         // position_now[31:0], zero pad
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [IdxW-1:0] cfg_index_i,
  input  logic [GainW-1:0] cfg_data_i
);

  gains_t gains_q;
  logic   tick_valid;
  logic   tick_ready;
  tick_t  tick;
  logic   law_valid;
  logic   law_ready;
  law_t   law;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gains_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_KP:  gains_q.kp <= cfg_data_i;
        REG_KD:  gains_q.kd <= cfg_data_i;
        REG_KI:  gains_q.ki <= cfg_data_i;
        default: gains_q    <= gains_q;
      endcase
    end
  end

  epid_track u_track (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .opcode_i     (s_axis_tuser[0]),
    .enc_a_i      (s_axis_tdata[0]),
    .enc_b_i      (s_axis_tdata[1]),
    .target_i     (s_axis_tdata[33:2]),
    .tick_valid_o (tick_valid),
    .tick_ready_i (tick_ready),
    .tick_o       (tick)
  );

  epid_law u_law (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .gains_i      (gains_q),
    .tick_valid_i (tick_valid),
    .tick_ready_o (tick_ready),
    .tick_i       (tick),
    .law_valid_o  (law_valid),
    .law_ready_i  (law_ready),
    .law_o        (law)
  );

  epid_drive u_drive (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .law_valid_i (law_valid),
    .law_ready_o (law_ready),
    .law_i       (law),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

@@ rtl/epid_checker.sv @@
// ----------------------------------------------------------------------------
// Encoder PID controller checker
// Port-level properties of the controller, bound to the top level.
// ----------------------------------------------------------------------------
module epid_checker import epid_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);

  logic [3:0] open_q;
  logic       tick_in;
  logic       beat_out;

  assign tick_in  = s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == OP_TICK);
  assign beat_out = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else begin
      open_q <= open_q + {3'd0, tick_in} - {3'd0, beat_out};
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled result beat changed.");

  a_dir_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[8] != m_axis_tdata[9])
    else $error("Bridge direction bits are not complementary.");

  a_no_orphan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> open_q != 4'd0)
    else $error("Result beat without an accepted tick.");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= 4'd6)
    else $error("More ticks in flight than pipeline stages.");

endmodule

bind encoder_pid_position_controller epid_checker u_epid_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
